### sv/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and codes for the stream find-and-replace core
// Payload structs of the request and response channels and the indexes
// of the configuration registers.
// ----------------------------------------------------------------------------
package sfr_pkg;

   // Width of the configuration write data, set by the widest register.
   localparam int CSR_DATA_W = 64;

   // Configuration register indexes, in register-map order.
   typedef enum logic [1:0] {
      CSR_PATTERN_LEN   = 2'd0,
      CSR_PATTERN_BYTES = 2'd1,
      CSR_REPLACE_LEN   = 2'd2,
      CSR_REPLACE_BYTES = 2'd3
   } csr_index_type;

   // One input byte of the string.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   // One output byte, or an empty end marker when byte_present is low.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       out_last;
   } rsp_type;

endpackage

### sv/stream_find_replace_core.sv
// ----------------------------------------------------------------------------
// stream_find_replace_core: streaming search and replace on a byte string
// Replaces every leftmost, non-overlapping occurrence of a configured
// pattern with a configured replacement, under control of a small
// microprogram held in a read-only table.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Transaction carries
//   -------   ---------  -------------------  ---------------------------------
//   req_      in         req_valid/req_ready  one string byte and its last flag
//   rsp_      out        rsp_valid/rsp_ready  one output byte or an end marker
//   csr_      in         csr_we (no wait)     one register write, index + data
//
// An input transaction emits E data bytes, where E is 0 to 8; an empty
// end marker leaves on the final step. The emit steps retire one output
// byte per cycle, when not stalled, through the single output register.
// Backpressure on rsp_ stalls the sequencer on any emit step that holds a
// byte or the end marker; req_ready is high only on the wait step.
// Reset is synchronous and active high; it empties the match window, clears
// the configuration registers and drops rsp_valid.
//
// Microprogram: WAIT takes a byte and appends it to the window. TEST checks
// for a full match. REPL emits the replacement bytes and CLRW empties the
// window. SCAN emits head bytes until what remains is a proper prefix of the
// pattern. TAIL flushes the window when the byte was the last of the string.
// END emits an empty end marker when the last byte produced nothing at all.
//
module stream_find_replace_core #(
   parameter int MAX_PATTERN = 8,
   parameter int MAX_REPLACE = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sfr_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sfr_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  sfr_pkg::csr_index_type              csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sfr_pkg::*;

   // Fill count holds 0..MAX_PATTERN, replacement index 0..MAX_REPLACE.
   localparam int FW = $clog2(MAX_PATTERN + 1);
   localparam int RW = $clog2(MAX_REPLACE + 1);

   // Microprogram step addresses.
   typedef enum logic [2:0] {
      S_WAIT = 3'd0,
      S_TEST = 3'd1,
      S_REPL = 3'd2,
      S_CLRW = 3'd3,
      S_SCAN = 3'd4,
      S_TAIL = 3'd5,
      S_END  = 3'd6
   } step_type;

   // Branch conditions tested by a control word.
   typedef enum logic [2:0] {
      C_ALWAYS    = 3'd0,
      C_REQ       = 3'd1,
      C_FULL      = 3'd2,
      C_REPL_DONE = 3'd3,
      C_SCAN_DONE = 3'd4,
      C_TAIL_DONE = 3'd5
   } cond_type;

   // Source of the byte emitted by a step.
   typedef enum logic [1:0] {
      E_NONE   = 2'd0,
      E_REPL   = 2'd1,
      E_HEAD   = 2'd2,
      E_MARKER = 2'd3
   } emit_type;

   // Window action applied when the condition is true.
   typedef enum logic [1:0] {
      A_NONE  = 2'd0,
      A_LOAD  = 2'd1,
      A_CLEAR = 2'd2
   } act_type;

   typedef struct packed {
      logic     accept;
      cond_type cond;
      emit_type emit;
      act_type  act;
      step_type jump_t;
      step_type jump_f;
   } cw_type;

   // The control store. Emitting loops stay on their own step until done.
   function automatic cw_type rom(input step_type s);
      cw_type w;
      w = '{1'b0, C_ALWAYS, E_NONE, A_NONE, S_WAIT, S_WAIT};
      case (s)
         S_WAIT: w = '{1'b1, C_REQ,       E_NONE,   A_LOAD,  S_TEST, S_WAIT};
         S_TEST: w = '{1'b0, C_FULL,      E_NONE,   A_NONE,  S_REPL, S_SCAN};
         S_REPL: w = '{1'b0, C_REPL_DONE, E_REPL,   A_NONE,  S_CLRW, S_REPL};
         S_CLRW: w = '{1'b0, C_ALWAYS,    E_NONE,   A_CLEAR, S_END,  S_END};
         S_SCAN: w = '{1'b0, C_SCAN_DONE, E_HEAD,   A_NONE,  S_TAIL, S_SCAN};
         S_TAIL: w = '{1'b0, C_TAIL_DONE, E_HEAD,   A_NONE,  S_END,  S_TAIL};
         S_END:  w = '{1'b0, C_ALWAYS,    E_MARKER, A_NONE,  S_WAIT, S_WAIT};
         default: w = '{1'b0, C_ALWAYS,   E_NONE,   A_NONE,  S_WAIT, S_WAIT};
      endcase
      return w;
   endfunction

   // Configuration registers.
   logic [3:0]            plen_cfg_ff, plen_cfg_in;
   logic [CSR_DATA_W-1:0] pat_ff, pat_in;
   logic [3:0]            rlen_cfg_ff, rlen_cfg_in;
   logic [CSR_DATA_W-1:0] rep_ff, rep_in;

   // Sequencer and datapath registers.
   step_type   step_ff, step_in;
   logic [7:0] win_ff [MAX_PATTERN];
   logic [7:0] win_in [MAX_PATTERN];
   logic [FW-1:0] fill_ff, fill_in;
   logic [RW-1:0] ridx_ff, ridx_in;
   logic       last_ff, last_in;
   logic       emitted_ff, emitted_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   cw_type        cw;
   logic [FW-1:0] plen;
   logic [RW-1:0] rlen;
   logic [MAX_PATTERN-1:0] eq_vec, in_fill;
   logic          prefix_all, full_match, proper_prefix;
   logic          cond_hit, emit_req, out_free, stall;
   logic [7:0]    rep_byte [8];
   logic [7:0]    emit_byte;
   logic          emit_present, emit_last;

   always_comb begin
      cw = rom(step_ff);

      // Lengths above the window or replacement capacity saturate.
      plen = (plen_cfg_ff > 4'(MAX_PATTERN)) ? FW'(MAX_PATTERN) : FW'(plen_cfg_ff);
      rlen = (rlen_cfg_ff > 4'(MAX_REPLACE)) ? RW'(MAX_REPLACE) : RW'(rlen_cfg_ff);

      // The held bytes always start at the window head, so the prefix test
      // compares fixed positions only.
      for (int j = 0; j < MAX_PATTERN; j++) begin
         eq_vec[j]  = (win_ff[j] == pat_ff[8*j +: 8]);
         in_fill[j] = (FW'(j) < fill_ff);
      end
      prefix_all    = &(eq_vec | ~in_fill);
      full_match    = (plen != '0) && (fill_ff == plen) && prefix_all;
      proper_prefix = (fill_ff < plen) && prefix_all;

      for (int j = 0; j < 8; j++) begin
         rep_byte[j] = rep_ff[8*j +: 8];
      end

      case (cw.cond)
         C_ALWAYS:    cond_hit = 1'b1;
         C_REQ:       cond_hit = req_valid;
         C_FULL:      cond_hit = full_match;
         C_REPL_DONE: cond_hit = (ridx_ff >= rlen);
         C_SCAN_DONE: cond_hit = (fill_ff == '0) || proper_prefix;
         C_TAIL_DONE: cond_hit = !last_ff || (fill_ff == '0);
         default:     cond_hit = 1'b1;
      endcase

      // What the step would emit, and whether that byte ends the string.
      emit_byte    = 8'd0;
      emit_present = 1'b1;
      emit_last    = 1'b0;
      case (cw.emit)
         E_NONE: begin
            emit_req = 1'b0;
         end
         E_REPL: begin
            emit_req  = !cond_hit;
            emit_byte = rep_byte[3'(ridx_ff)];
            emit_last = last_ff && (ridx_ff + RW'(1) == rlen);
         end
         E_HEAD: begin
            emit_req  = !cond_hit;
            emit_byte = win_ff[0];
            emit_last = last_ff && (fill_ff == FW'(1));
         end
         E_MARKER: begin
            emit_req     = last_ff && !emitted_ff;
            emit_present = 1'b0;
            emit_last    = 1'b1;
         end
         default: begin
            emit_req = 1'b0;
         end
      endcase

      out_free = !rsp_valid_ff || rsp_ready;
      stall    = emit_req && !out_free;

      // Defaults: hold everything, drain the output register when taken.
      step_in      = step_ff;
      win_in       = win_ff;
      fill_in      = fill_ff;
      ridx_in      = ridx_ff;
      last_in      = last_ff;
      emitted_in   = emitted_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (!stall) begin
         step_in = cond_hit ? cw.jump_t : cw.jump_f;

         if (cond_hit) begin
            case (cw.act)
               A_NONE: begin
               end
               A_LOAD: begin
                  for (int j = 0; j < MAX_PATTERN; j++) begin
                     if (FW'(j) == fill_ff) begin
                        win_in[j] = req_data.in_byte;
                     end
                  end
                  fill_in    = fill_ff + FW'(1);
                  last_in    = req_data.in_last;
                  ridx_in    = '0;
                  emitted_in = 1'b0;
               end
               A_CLEAR: begin
                  fill_in = '0;
               end
               default: begin
               end
            endcase
         end

         if (emit_req) begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.out_byte     = emit_byte;
            rsp_data_in.byte_present = emit_present;
            rsp_data_in.out_last     = emit_last;
            emitted_in               = 1'b1;
            if (cw.emit == E_REPL) begin
               ridx_in = ridx_ff + RW'(1);
            end
            if (cw.emit == E_HEAD) begin
               // Retire the head byte and move the rest down one place.
               for (int j = 0; j < MAX_PATTERN - 1; j++) begin
                  win_in[j] = win_ff[j + 1];
               end
               fill_in = fill_ff - FW'(1);
            end
         end
      end

      // Configuration writes take effect at the next edge; the host must issue
      // them only while the sequencer is idle, which the block does not enforce.
      plen_cfg_in = plen_cfg_ff;
      pat_in      = pat_ff;
      rlen_cfg_in = rlen_cfg_ff;
      rep_in      = rep_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_LEN:   plen_cfg_in = csr_wdata[3:0];
            CSR_PATTERN_BYTES: pat_in      = csr_wdata;
            CSR_REPLACE_LEN:   rlen_cfg_in = csr_wdata[3:0];
            CSR_REPLACE_BYTES: rep_in      = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      ridx_ff     <= ridx_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         step_ff      <= S_WAIT;
         fill_ff      <= '0;
         emitted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         plen_cfg_ff  <= '0;
         pat_ff       <= '0;
         rlen_cfg_ff  <= '0;
         rep_ff       <= '0;
      end else begin
         step_ff      <= step_in;
         fill_ff      <= fill_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
         plen_cfg_ff  <= plen_cfg_in;
         pat_ff       <= pat_in;
         rlen_cfg_ff  <= rlen_cfg_in;
         rep_ff       <= rep_in;
      end
   end

   assign req_ready = cw.accept;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/stream_find_replace_checker.sv
// ----------------------------------------------------------------------------
// stream_find_replace_checker: port-level assertions for the core
// Watches the channels of the top level and flags behavior that the
// sequencer and output register must never show.
// ----------------------------------------------------------------------------
module stream_find_replace_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input sfr_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sfr_pkg::rsp_type rsp_data
);
   import sfr_pkg::*;

   // A response that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed or dropped while stalled");

   // An empty end marker always closes the string and carries a zero byte.
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_present |-> rsp_data.out_last && rsp_data.out_byte == 8'd0)
      else $error("empty marker without last flag or with data");

   // Once a byte is taken the sequencer is busy with it, so req_ready is low in the cycle after.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on consecutive cycles");

   // Reset leaves no response pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind stream_find_replace_core stream_find_replace_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### test/stream_find_replace_core_tb.sv
// ----------------------------------------------------------------------------
// stream_find_replace_core_tb: self-checking bench for the find-and-replace core
// A queue-fed driver sends string bytes in random bursts while the receiver
// stalls on its own schedule. Every accepted byte runs through a software
// copy of the search-and-replace behavior. The monitor then checks each
// output transaction against the oldest predicted output byte or end marker.
// ----------------------------------------------------------------------------
module stream_find_replace_core_tb;
   import sfr_pkg::*;

   // Cycles of quiet after the last output before the block is surely idle.
   // A byte that produces nothing still walks the sequencer through its steps.
   localparam int DRAIN_CYCLES   = 16;
   // Cycles with no accepted transaction on either channel before giving up.
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_BYTES    = 34;
   localparam int MAX_PRINTED    = 100;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_PATTERN_LEN;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   stream_find_replace_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // String bytes waiting to be sent, and output transactions still owed.
   req_type     pend_bytes_q[$];
   rsp_type     out_stream_q[$];
   rsp_type     want_rsp;

   // Shadow of the configuration registers, updated as they are written.
   logic [3:0]  pat_len_r = '0;
   logic [63:0] pat_r     = '0;
   logic [3:0]  rep_len_r = '0;
   logic [63:0] rep_r     = '0;

   // Shadow of the match window: held bytes, oldest in bits 7..0.
   logic [63:0] win_r     = '0;
   int          win_fill  = 0;

   int          errors        = 0;
   int          bytes_sent    = 0;
   int          results_seen  = 0;
   int          matches_found = 0;
   int          phases_run    = 0;
   int          burst_left    = 1;
   int          gap_left      = 0;
   int          stall_cycles  = 0;
   logic [15:0] ready_cyc     = '0;

   // Prints one line per mismatch, up to a cap, and counts all of them.
   task automatic report(input string msg);
      if (errors < MAX_PRINTED)
         $display("ERROR: %s", msg);
      errors++;
   endtask

   // True when len bytes of the candidate, starting at start, equal the
   // first len bytes of the current pattern.
   function automatic bit prefix_hits(input logic [71:0] cand, input int start, input int len);
      bit ok;
      ok = 1'b1;
      for (int i = 0; i < len; i++)
         if (cand[8*(start+i) +: 8] != pat_r[8*i +: 8])
            ok = 1'b0;
      return ok;
   endfunction

   // Works out the output transactions that one accepted string byte causes,
   // appends them to the owed list and advances the shadow window.
   task automatic search_replace_byte(input req_type item);
      logic [71:0] cand;
      rsp_type     res [0:8];
      int          plen;
      int          rlen;
      int          n;
      int          k;
      int          cnt;
      plen = (pat_len_r > 4'd8) ? 8 : int'(pat_len_r);
      rlen = (rep_len_r > 4'd8) ? 8 : int'(rep_len_r);
      n    = (win_fill > 7) ? 7 : win_fill;
      cand = '0;
      cand[63:0] = win_r;
      cand[8*n +: 8] = item.in_byte;
      n++;
      k   = 0;
      cnt = 0;
      if (plen > 0 && n == plen && prefix_hits(cand, 0, n)) begin
         // Full match from the oldest held byte: emit the replacement.
         for (int i = 0; i < rlen; i++) begin
            res[cnt] = {rep_r[8*i +: 8], 1'b1, 1'b0};
            cnt++;
         end
         k = n;
         matches_found++;
      end else begin
         // Drop head bytes until what is left could still grow into a match.
         while (k < n && !((n - k) < plen && prefix_hits(cand, k, n - k))) begin
            res[cnt] = {cand[8*k +: 8], 1'b1, 1'b0};
            cnt++;
            k++;
         end
      end
      if (item.in_last) begin
         while (k < n) begin
            res[cnt] = {cand[8*k +: 8], 1'b1, 1'b0};
            cnt++;
            k++;
         end
         // An empty replacement on the final byte leaves only an end marker.
         if (cnt == 0) begin
            res[0] = {8'h00, 1'b0, 1'b0};
            cnt = 1;
         end
         res[cnt-1].out_last = 1'b1;
         win_r    = '0;
         win_fill = 0;
      end else begin
         win_r = '0;
         for (int i = 0; k + i < n && i < 8; i++)
            win_r[8*i +: 8] = cand[8*(k+i) +: 8];
         win_fill = n - k;
      end
      for (int i = 0; i < cnt; i++)
         out_stream_q.push_back(res[i]);
   endtask

   // Driver: presents queued bytes in bursts of random length separated by
   // random gaps. A byte stays on the bus until its transaction completes.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready) begin
            search_replace_byte(req_data);
            bytes_sent++;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(24, 1);
               // About a quarter of the bursts run straight into the next one.
               gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
            end
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pend_bytes_q.size() > 0) begin
               req_data  <= pend_bytes_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: cycles through four back-pressure modes in turn: always ready,
   // mostly ready, a fixed 2-of-8 window, and mostly stalled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         ready_cyc <= ready_cyc + 16'd1;
         case (ready_cyc[8:7])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= ($urandom_range(9) < 7);
            2'd2: rsp_ready <= (ready_cyc[2:0] >= 3'd6);
            default: rsp_ready <= ($urandom_range(9) < 3);
         endcase
      end
   end

   // Monitor: every output transaction must match the oldest owed result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (out_stream_q.size() == 0) begin
            report($sformatf("output with nothing owed: byte %h present %b last %b",
                             rsp_data.out_byte, rsp_data.byte_present, rsp_data.out_last));
         end else begin
            want_rsp = out_stream_q.pop_front();
            if (rsp_data.out_byte !== want_rsp.out_byte ||
                rsp_data.byte_present !== want_rsp.byte_present ||
                rsp_data.out_last !== want_rsp.out_last)
               report($sformatf("output %0d: got byte %h present %b last %b, want %h %b %b",
                                results_seen, rsp_data.out_byte, rsp_data.byte_present,
                                rsp_data.out_last, want_rsp.out_byte,
                                want_rsp.byte_present, want_rsp.out_last));
         end
      end
   end

   // Watchdog: a run that stops moving on both channels is a failure.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic last);
      pend_bytes_q.push_back({b, last});
   endtask

   // Waits until every byte is sent and every owed output has arrived, then
   // lets the sequencer finish any byte that produced no output.
   task automatic wait_idle();
      @(negedge clock);
      while (pend_bytes_q.size() != 0 || req_valid || out_stream_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [63:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_PATTERN_LEN:   pat_len_r = val[3:0];
         CSR_PATTERN_BYTES: pat_r     = val;
         CSR_REPLACE_LEN:   rep_len_r = val[3:0];
         default:           rep_r     = val;
      endcase
   endtask

   // Writes all four registers back to back. Only the low nibble of a length
   // register is kept, so the upper data bits may carry anything.
   task automatic set_config(input logic [63:0] plen_w, input logic [63:0] pat_w,
                             input logic [63:0] rlen_w, input logic [63:0] rep_w);
      csr_write(CSR_PATTERN_LEN, plen_w);
      csr_write(CSR_PATTERN_BYTES, pat_w);
      csr_write(CSR_REPLACE_LEN, rlen_w);
      csr_write(CSR_REPLACE_BYTES, rep_w);
      @(posedge clock);
      csr_we <= 1'b0;
      phases_run++;
   endtask

   // One random configuration followed by a stream built mostly from whole
   // patterns and pattern prefixes over a small alphabet, so that matches,
   // near misses and overlaps are common, with some noise bytes mixed in.
   // The phase may end in the middle of a string, so the next configuration
   // sees a partly filled window.
   task automatic random_phase(input int idx);
      logic [7:0]  alpha [0:2];
      logic [63:0] upper;
      logic [3:0]  plen_n;
      logic [3:0]  rlen_n;
      logic [63:0] pat_w;
      logic [7:0]  b;
      logic        last;
      int          plen_eff;
      int          made;
      int          kind;
      int          len;
      for (int i = 0; i < 3; i++)
         alpha[i] = 8'($urandom);
      case (idx)
         0:       begin plen_n = 4'd8;  rlen_n = 4'd0;  end
         1:       begin plen_n = 4'd1;  rlen_n = 4'd8;  end
         2:       begin plen_n = 4'd0;  rlen_n = 4'($urandom_range(8)); end
         3:       begin plen_n = 4'd12; rlen_n = 4'd15; end
         default: begin
            plen_n = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                              : 4'($urandom_range(5, 1));
            rlen_n = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                              : 4'($urandom_range(8));
         end
      endcase
      plen_eff = (plen_n > 4'd8) ? 8 : int'(plen_n);
      pat_w = {$urandom, $urandom};
      for (int i = 0; i < plen_eff; i++)
         pat_w[8*i +: 8] = alpha[$urandom_range(2)];
      upper = {$urandom, $urandom};
      set_config($urandom_range(1) ? {upper[63:4], plen_n} : {60'd0, plen_n}, pat_w,
                 $urandom_range(1) ? {upper[3:0], upper[63:8], rlen_n} : {60'd0, rlen_n},
                 {$urandom, $urandom});
      made = 0;
      while (made < PHASE_BYTES) begin
         kind = $urandom_range(9);
         if (plen_eff == 0 && kind <= 5)
            kind = 6;
         if (kind <= 3)
            len = plen_eff;
         else if (kind <= 5)
            len = $urandom_range(plen_eff, 1);
         else if (kind <= 8)
            len = $urandom_range(3, 1);
         else
            len = 1;
         for (int j = 0; j < len; j++) begin
            if (kind <= 5)
               b = pat_w[8*j +: 8];
            else if (kind <= 8)
               b = alpha[$urandom_range(2)];
            else
               b = 8'($urandom);
            last = (j == len - 1 && $urandom_range(4) == 0) || ($urandom_range(24) == 0);
            queue_byte(b, last);
         end
         made += len;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // Zero pattern length with all-zero registers: bytes pass straight
      // through, including the all-zero and all-one byte values.
      set_config(64'd0, 64'd0, 64'd0, 64'd0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b1);
      wait_idle();

      // Three-byte pattern "abc" replaced by "XY": one match, then a near miss
      // on the final byte whose scan drains the window.
      set_config(64'd3, 64'h0000_0000_0063_6261, 64'd2, 64'h0000_0000_0000_5958);
      queue_byte(8'h61, 1'b0);
      queue_byte(8'h62, 1'b0);
      queue_byte(8'h63, 1'b0);
      queue_byte(8'h61, 1'b0);
      queue_byte(8'h62, 1'b0);
      queue_byte(8'h64, 1'b1);
      wait_idle();

      // Empty replacement: a match on the final byte leaves nothing to send,
      // so only an end marker comes out. Then an odd run of "a" flushes one.
      set_config(64'd2, 64'h0000_0000_0000_6161, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_byte(8'h61, 1'b0);
      queue_byte(8'h61, 1'b1);
      queue_byte(8'h61, 1'b0);
      queue_byte(8'h61, 1'b0);
      queue_byte(8'h61, 1'b1);
      wait_idle();

      // Oversized lengths (all data bits set) clamp to eight bytes. A full
      // eight-byte match ends a string, then four pattern bytes stay held.
      set_config(64'hFFFF_FFFF_FFFF_FFFF, 64'hFE7F_8001_AA55_FF00,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'h00FF_00FF_FF00_FF00);
      for (int i = 0; i < 8; i++)
         queue_byte(8'(64'hFE7F_8001_AA55_FF00 >> (8 * i)), i == 7);
      for (int i = 0; i < 4; i++)
         queue_byte(8'(64'hFE7F_8001_AA55_FF00 >> (8 * i)), 1'b0);
      wait_idle();

      // Pattern changed while bytes are held: the final byte makes the window
      // be scanned against the new two-byte pattern, which drains it.
      set_config(64'd2, 64'h0000_0000_0000_55FF, 64'd1, 64'h0000_0000_0000_00A5);
      queue_byte(8'h01, 1'b1);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         random_phase(p);
         wait_idle();
      end

      $display("Sent %0d string bytes under %0d configurations, including a mid-string change.",
               bytes_sent, phases_run);
      $display("Checked %0d output transactions covering %0d pattern replacements.",
               results_seen, matches_found);
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

### files.f
sv/sfr_pkg.sv
sv/stream_find_replace_core.sv
sv/stream_find_replace_checker.sv
test/stream_find_replace_core_tb.sv
